### hw/rtl/aarch32_banked_register_access_unit_assert.svh
// Assertion macros for the banked register access unit.
// Needs clk and arst_n in the scope of each use.
`ifndef AARCH32_BANKED_REGISTER_ACCESS_UNIT_ASSERT_SVH
`define AARCH32_BANKED_REGISTER_ACCESS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABRAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("abrau: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ABRAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("abrau: next-cycle check failed");

`endif

### hw/rtl/abrau_pkg.sv
// Shared constants and types of the banked register access unit.
// No dependencies.
package abrau_pkg;

	localparam int unsigned DATA_W   = 64;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DEPTH    = 32;
	localparam int unsigned NUM_GPRS = 30;

	// Storage map: entries 0..29 general, 30 link register, 31 program counter.
	localparam logic [ADDR_W-1:0] LR_ADDR = 5'd30;
	localparam logic [ADDR_W-1:0] PC_ADDR = 5'd31;
	localparam logic [ADDR_W-1:0] FIQ_BANK_OFS = 5'd16;

	localparam logic [DATA_W-1:0] LOW32 = 64'h0000_0000_FFFF_FFFF;

	localparam logic [4:0] MODE_USR = 5'h10;
	localparam logic [4:0] MODE_FIQ = 5'h11;
	localparam logic [4:0] MODE_IRQ = 5'h12;
	localparam logic [4:0] MODE_SVC = 5'h13;
	localparam logic [4:0] MODE_ABT = 5'h17;
	localparam logic [4:0] MODE_HYP = 5'h1A;
	localparam logic [4:0] MODE_UND = 5'h1B;
	localparam logic [4:0] MODE_SYS = 5'h1F;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              no_reg;
	} abrau_dec_t;

endpackage

### hw/rtl/abrau_req_if.sv
// Request channel of the banked register access unit.
// Depends on abrau_pkg.
interface abrau_req_if import abrau_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [4:0]        reg_index;
	logic [DATA_W-1:0] write_data;
	logic              aarch32_state;
	logic [4:0]        cpu_mode;

	modport source (output valid, func, reg_index, write_data, aarch32_state, cpu_mode,
		input ready);
	modport sink (input valid, func, reg_index, write_data, aarch32_state, cpu_mode,
		output ready);
endinterface

### hw/rtl/abrau_rsp_if.sv
// Response channel of the banked register access unit.
// Depends on abrau_pkg.
interface abrau_rsp_if import abrau_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              no_register;

	modport source (output valid, read_data, no_register, input ready);
	modport sink (input valid, read_data, no_register, output ready);
endinterface

### hw/rtl/abrau_regmem.sv
// Register storage: 32 x 64 synchronous memory, one write and one read port.
// Per-entry valid bits make never-written entries read as zero. Uses abrau_pkg.
module abrau_regmem import abrau_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### hw/rtl/abrau_decode.sv
// Register selection: maps index, execution state and mode to a storage entry.
// Uses abrau_pkg.
module abrau_decode import abrau_pkg::*; (
	input  logic       aarch32_state,
	input  logic [4:0] reg_index,
	input  logic [4:0] cpu_mode,
	output abrau_dec_t dec
);

	logic [3:0] r;

	assign r = reg_index[3:0];

	always_comb begin
		dec.addr   = reg_index;
		dec.no_reg = 1'b0;
		if (!aarch32_state) begin
			// x0..x29 and the link register share their storage address with the index
			dec.no_reg = (reg_index == PC_ADDR);
		end else if (r <= 4'd7) begin
			dec.addr = {1'b0, r};
		end else if (r <= 4'd12) begin
			dec.addr = (cpu_mode == MODE_FIQ) ? ({1'b0, r} + FIQ_BANK_OFS) : {1'b0, r};
		end else if (r == 4'd13) begin
			case (cpu_mode)
				MODE_USR, MODE_SYS: dec.addr = 5'd13;
				MODE_FIQ:           dec.addr = 5'd29;
				MODE_IRQ:           dec.addr = 5'd17;
				MODE_SVC:           dec.addr = 5'd19;
				MODE_ABT:           dec.addr = 5'd21;
				MODE_UND:           dec.addr = 5'd23;
				MODE_HYP:           dec.addr = 5'd15;
				default:            dec.no_reg = 1'b1;
			endcase
		end else if (r == 4'd14) begin
			case (cpu_mode)
				MODE_USR, MODE_SYS, MODE_HYP: dec.addr = 5'd14;
				MODE_FIQ:                     dec.addr = LR_ADDR;
				MODE_IRQ:                     dec.addr = 5'd16;
				MODE_SVC:                     dec.addr = 5'd18;
				MODE_ABT:                     dec.addr = 5'd20;
				MODE_UND:                     dec.addr = 5'd22;
				default:                      dec.no_reg = 1'b1;
			endcase
		end else begin
			dec.addr = PC_ADDR;
		end
	end

endmodule

### hw/rtl/aarch32_banked_register_access_unit.sv
// Top level of the banked register access unit.
// Uses abrau_pkg, abrau_req_if, abrau_rsp_if, abrau_decode, abrau_regmem.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------
//  req     | in  | func, reg_index, write_data, aarch32_state, cpu_mode
//  rsp     | out | read_data, no_register
//
// One access per cycle unless rsp stalls; the result comes the cycle after the beat.
// Writes go to memory at the request beat; reads sample memory at the same
// edge, so a read right after a write sees it without forwarding.
// Reset clears all 32 valid bits at once: every register reads zero, no sweep.
// A stalled response holds the result and blocks new request beats.
module aarch32_banked_register_access_unit import abrau_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	abrau_req_if.sink  req,
	abrau_rsp_if.source rsp
);

	`include "aarch32_banked_register_access_unit_assert.svh"

	abrau_dec_t        dec;
	logic              accept;
	logic              wr_en;
	logic              rd_en;
	logic [DATA_W-1:0] wr_data;
	logic [DATA_W-1:0] rd_data;

	logic              v_s1;
	logic              is_wr_s1;
	logic              a32_s1;
	logic              nreg_s1;

	abrau_decode u_decode (
		.aarch32_state (req.aarch32_state),
		.reg_index     (req.reg_index),
		.cpu_mode      (req.cpu_mode),
		.dec           (dec)
	);

	assign req.ready = !v_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign wr_en     = accept && (req.func == FUNC_WRITE) && !dec.no_reg;
	assign rd_en     = accept && (req.func == FUNC_READ) && !dec.no_reg;
	assign wr_data   = req.aarch32_state ? (req.write_data & LOW32) : req.write_data;

	abrau_regmem u_regmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (dec.addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (dec.addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (rsp.ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_wr_s1 <= (req.func == FUNC_WRITE);
			a32_s1   <= req.aarch32_state;
			nreg_s1  <= dec.no_reg;
		end
	end

	assign rsp.valid       = v_s1;
	assign rsp.no_register = nreg_s1;

	always_comb begin
		if (is_wr_s1 || nreg_s1) begin
			rsp.read_data = '0;
		end else if (a32_s1) begin
			rsp.read_data = rd_data & LOW32;
		end else begin
			rsp.read_data = rd_data;
		end
	end

	`ABRAU_ASSERT_NEXT(a_write_gives_zero, accept && (req.func == FUNC_WRITE), rsp.valid && (rsp.read_data == '0))
	`ABRAU_ASSERT_NOW(a_noreg_reads_zero, rsp.valid && rsp.no_register, rsp.read_data == '0)
	`ABRAU_ASSERT_NOW(a_a32_upper_zero, rsp.valid && a32_s1, rsp.read_data[63:32] == 32'd0)
	`ABRAU_ASSERT_NOW(a_no_write_on_noreg, wr_en || rd_en, !dec.no_reg && accept)

endmodule
